/* rtl/rsc_pkg.sv */
// Shared constants and types for the regex syntax checker.
package rsc_pkg;

  // Characters with a meaning in the pattern syntax.
  localparam logic [7:0] CH_ALT  = 8'h7C;
  localparam logic [7:0] CH_ESC  = 8'h5C;
  localparam logic [7:0] CH_LBR  = 8'h5B;
  localparam logic [7:0] CH_RBR  = 8'h5D;
  localparam logic [7:0] CH_LPA  = 8'h28;
  localparam logic [7:0] CH_RPA  = 8'h29;
  localparam logic [7:0] CH_STAR = 8'h2A;
  localparam logic [7:0] CH_QUES = 8'h3F;
  localparam logic [7:0] CH_PLUS = 8'h2B;
  localparam logic [7:0] CH_DASH = 8'h2D;

  // Error codes.
  localparam logic [3:0] ERR_NONE          = 4'd0;
  localparam logic [3:0] ERR_EMPTY_ALT     = 4'd1;
  localparam logic [3:0] ERR_NESTED_BRK    = 4'd2;
  localparam logic [3:0] ERR_EMPTY_BRK     = 4'd3;
  localparam logic [3:0] ERR_NO_LEFT_BRK   = 4'd4;
  localparam logic [3:0] ERR_EMPTY_GROUP   = 4'd5;
  localparam logic [3:0] ERR_NO_LEFT_PAR   = 4'd6;
  localparam logic [3:0] ERR_QUAL_START    = 4'd7;
  localparam logic [3:0] ERR_QUAL_QUAL     = 4'd8;
  localparam logic [3:0] ERR_QUAL_AFTER_OR = 4'd9;
  localparam logic [3:0] ERR_NO_RIGHT_PAR  = 4'd10;
  localparam logic [3:0] ERR_NO_RIGHT_BRK  = 4'd11;
  localparam logic [3:0] ERR_DEPTH         = 4'd12;

  // Verdict codes.
  localparam logic [1:0] VERDICT_RUNNING = 2'd0;
  localparam logic [1:0] VERDICT_ACCEPT  = 2'd1;
  localparam logic [1:0] VERDICT_REJECT  = 2'd2;

  // Warning bit positions.
  localparam int WARN_ALT_QUAL = 0;
  localparam int WARN_REVERSED = 1;
  localparam int WARN_SINGLE   = 2;

  // Check status carried from one character to the next.
  typedef struct packed {
    logic       failed;
    logic       bracket_open;
    logic [3:0] first_error;
  } chk_state_t;

endpackage

/* rtl/rsc_judge.sv */
// Judges one pattern character against its neighbors and the check status.
module rsc_judge #(
  parameter int unsigned MAX_NESTING = 255,
  parameter int unsigned DEPTH_W     = 8
) (
  input  logic [7:0]         prv,
  input  logic [7:0]         cur,
  input  logic [7:0]         nxt,
  input  logic               at_end,
  input  logic               first,
  input  rsc_pkg::chk_state_t st_in,
  input  logic [DEPTH_W-1:0] depth_in,
  output rsc_pkg::chk_state_t st_out,
  output logic [DEPTH_W-1:0] depth_out,
  output logic [2:0]         warn
);
  import rsc_pkg::*;

  localparam logic [DEPTH_W-1:0] DEPTH_MAX = DEPTH_W'(MAX_NESTING);

  logic       esc;
  logic       prv_qual;
  logic       cur_qual;
  logic [3:0] code;
  logic       brk_next;
  logic [DEPTH_W-1:0] depth_next;
  logic [2:0] warn_raw;

  assign esc      = (prv == CH_ESC);
  assign prv_qual = prv inside {CH_STAR, CH_QUES, CH_PLUS};
  assign cur_qual = cur inside {CH_STAR, CH_QUES, CH_PLUS};

  always_comb begin
    code       = ERR_NONE;
    brk_next   = st_in.bracket_open;
    depth_next = depth_in;
    warn_raw   = '0;

    // The alternative bar ignores escapes.
    if (cur == CH_ALT) begin
      if (first || prv == CH_ALT || prv == CH_LPA || at_end) begin
        code = ERR_EMPTY_ALT;
      end else if (prv == CH_STAR || prv == CH_QUES) begin
        warn_raw[WARN_ALT_QUAL] = 1'b1;
      end
    end else if (cur == CH_LBR && !esc) begin
      if (st_in.bracket_open) begin
        code = ERR_NESTED_BRK;
      end else begin
        brk_next = 1'b1;
      end
    end else if (cur == CH_RBR && !esc) begin
      if (prv == CH_LBR) begin
        code = ERR_EMPTY_BRK;
      end else if (!st_in.bracket_open) begin
        code = ERR_NO_LEFT_BRK;
      end else begin
        brk_next = 1'b0;
      end
    end else if (cur == CH_LPA && !esc) begin
      if (depth_in >= DEPTH_MAX) begin
        code = ERR_DEPTH;
      end else begin
        depth_next = depth_in + DEPTH_W'(1);
      end
    end else if (cur == CH_RPA && !esc) begin
      if (prv == CH_LPA) begin
        code = ERR_EMPTY_GROUP;
      end else if (depth_in == '0) begin
        code = ERR_NO_LEFT_PAR;
      end else begin
        depth_next = depth_in - DEPTH_W'(1);
      end
    end else if (cur_qual && !esc) begin
      if (first) begin
        code = ERR_QUAL_START;
      end else if (prv_qual) begin
        code = ERR_QUAL_QUAL;
      end else if (prv == CH_ALT) begin
        code = ERR_QUAL_AFTER_OR;
      end
    end else if (cur == CH_DASH && st_in.bracket_open) begin
      if (prv > nxt) begin
        warn_raw[WARN_REVERSED] = 1'b1;
      end else if (prv == nxt) begin
        warn_raw[WARN_SINGLE] = 1'b1;
      end
    end
  end

  always_comb begin
    st_out    = st_in;
    depth_out = depth_in;
    warn      = '0;
    if (!st_in.failed) begin
      if (code != ERR_NONE) begin
        st_out.failed      = 1'b1;
        st_out.first_error = code;
      end else begin
        st_out.bracket_open = brk_next;
        depth_out           = depth_next;
        warn                = warn_raw;
      end
    end
  end

endmodule

/* rtl/regex_syntax_checker.sv */
// Regex syntax checker top level: input register, check logic, result register.
//
// Usage: the pattern arrives one character per item on the input channel
// (char_value, is_last, in_valid/in_ready); is_last marks the final
// character. Every item gives exactly one result item on the output channel
// (verdict, error_code, warning_flags, error_position, last_result,
// out_valid/out_ready). A character is judged when the next one arrives, so
// its warnings show up on the following result; the last item judges both
// remaining characters and checks for unclosed groups and brackets.
// A result is registered: the accepting edge loads the input register, and the
// result register loads from it when the receiver is not stalling.
// Throughput: one item per cycle while out_ready stays high; all checks for an item
// are shallow compares and small counters between those two registers.
// The first error is latched and reported on every later result until the
// pattern ends; the result carrying last_result returns the checker to its
// reset state for the next pattern.
// Reset clears both registers' valid flags and all check state.
// When the receiver stalls, the result register holds, the input register
// fills, and in_ready drops until out_ready returns.
module regex_syntax_checker #(
  parameter int unsigned          MAX_NESTING = 255,
  parameter longint unsigned      MAX_LENGTH  = 65535
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] char_value,
  input  logic       is_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] verdict,
  output logic [3:0] error_code,
  output logic [2:0] warning_flags,
  output logic [15:0] error_position,
  output logic       last_result
);
  import rsc_pkg::*;

  localparam int unsigned DEPTH_W = $clog2(MAX_NESTING + 1);
  localparam int unsigned IDX_W   = $clog2(MAX_LENGTH + 1);
  localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(MAX_LENGTH);

  function automatic logic [15:0] clip_pos(input logic [IDX_W-1:0] p);
    logic [IDX_W+15:0] wide;
    wide = (IDX_W + 16)'(p);
    return (wide > (IDX_W + 16)'(16'hFFFF)) ? 16'hFFFF : wide[15:0];
  endfunction

  // Input register.
  logic       held_valid;
  logic [7:0] held_char;
  logic       held_last;
  logic       advance;

  // Check state.
  logic [7:0]         older_char;
  logic [7:0]         pending_char;
  logic               have_pending;
  logic [DEPTH_W-1:0] group_depth;
  logic [IDX_W-1:0]   char_index;
  chk_state_t         status;
  logic [15:0]        err_pos;

  // Next-state values.
  chk_state_t         st_a, st_1, st_b, status_next;
  logic [DEPTH_W-1:0] depth_a, depth_1, depth_b;
  logic [2:0]         warn_a, warn_b, warn_next;
  logic [IDX_W-1:0]   idx_1, idx_2;
  logic [7:0]         older_1;
  logic [15:0]        err_pos_next;

  assign advance  = held_valid && (!out_valid || out_ready);
  assign in_ready = !held_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_char <= char_value;
      held_last <= is_last;
    end
  end

  // Judge the pending character now that its successor is known.
  rsc_judge #(
    .MAX_NESTING (MAX_NESTING),
    .DEPTH_W     (DEPTH_W)
  ) u_judge_pend (
    .prv       (older_char),
    .cur       (pending_char),
    .nxt       (held_char),
    .at_end    (1'b0),
    .first     (char_index == '0),
    .st_in     (status),
    .depth_in  (group_depth),
    .st_out    (st_a),
    .depth_out (depth_a),
    .warn      (warn_a)
  );

  always_comb begin
    if (have_pending) begin
      st_1    = st_a;
      depth_1 = depth_a;
      older_1 = pending_char;
      idx_1   = (char_index == IDX_MAX) ? char_index : char_index + IDX_W'(1);
    end else begin
      st_1    = status;
      depth_1 = group_depth;
      older_1 = older_char;
      idx_1   = char_index;
    end
  end

  // Judge the final character; only used when the item closes the pattern.
  rsc_judge #(
    .MAX_NESTING (MAX_NESTING),
    .DEPTH_W     (DEPTH_W)
  ) u_judge_last (
    .prv       (older_1),
    .cur       (held_char),
    .nxt       (8'd0),
    .at_end    (1'b1),
    .first     (idx_1 == '0),
    .st_in     (st_1),
    .depth_in  (depth_1),
    .st_out    (st_b),
    .depth_out (depth_b),
    .warn      (warn_b)
  );

  assign idx_2 = (idx_1 == IDX_MAX) ? idx_1 : idx_1 + IDX_W'(1);

  always_comb begin
    err_pos_next = err_pos;
    if (st_1.failed && !status.failed) begin
      err_pos_next = clip_pos(char_index);
    end
    status_next = st_1;
    warn_next   = have_pending ? warn_a : 3'b000;
    if (held_last) begin
      status_next = st_b;
      warn_next   = warn_next | warn_b;
      if (st_b.failed && !st_1.failed) begin
        err_pos_next = clip_pos(idx_1);
      end
      // Unbalanced groups or brackets are reported one past the last character.
      if (!st_b.failed && depth_b != '0) begin
        status_next.failed      = 1'b1;
        status_next.first_error = ERR_NO_RIGHT_PAR;
        err_pos_next            = clip_pos(idx_2);
      end else if (!st_b.failed && st_b.bracket_open) begin
        status_next.failed      = 1'b1;
        status_next.first_error = ERR_NO_RIGHT_BRK;
        err_pos_next            = clip_pos(idx_2);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      older_char   <= '0;
      pending_char <= '0;
      have_pending <= 1'b0;
      group_depth  <= '0;
      char_index   <= '0;
      status       <= '0;
      err_pos      <= '0;
    end else if (advance) begin
      if (held_last) begin
        older_char   <= '0;
        pending_char <= '0;
        have_pending <= 1'b0;
        group_depth  <= '0;
        char_index   <= '0;
        status       <= '0;
        err_pos      <= '0;
      end else begin
        older_char   <= older_1;
        pending_char <= held_char;
        have_pending <= 1'b1;
        group_depth  <= depth_1;
        char_index   <= idx_1;
        status       <= status_next;
        err_pos      <= err_pos_next;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      if (status_next.failed) begin
        verdict        <= VERDICT_REJECT;
        error_code     <= status_next.first_error;
        error_position <= err_pos_next;
      end else begin
        verdict        <= held_last ? VERDICT_ACCEPT : VERDICT_RUNNING;
        error_code     <= ERR_NONE;
        error_position <= '0;
      end
      warning_flags <= warn_next;
      last_result   <= held_last;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    out_valid && verdict == VERDICT_ACCEPT |-> last_result)
    else $error("accept verdict without pattern end");

  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((verdict == VERDICT_REJECT) == (error_code != ERR_NONE)))
    else $error("error code does not match verdict");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && verdict != VERDICT_REJECT |-> error_position == 16'd0)
    else $error("error position set without an error");

  assert property (@(posedge clk) disable iff (rst)
    advance && held_last |=> !have_pending && char_index == '0 && !status.failed
                             && group_depth == '0)
    else $error("check state not cleared after pattern end");

endmodule
